// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file rbm_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define RBM_ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Short form for modules with clk_i / rst_ni.
`define RBM_ASSERT(lbl, prop, msg) \
  `RBM_ASSERT_IMPL(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/rbm_pkg.sv -----
// Package for the RGB box mean filter: config register codes and reset values.
// No dependencies.
`default_nettype none

package rbm_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [15:0] RST_HEIGHT = 16'd480;
  localparam logic [3:0]  RST_WINDOW = 4'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/rbm_if.sv -----
// Valid/ready interfaces for the pixel input and result channels.
// No dependencies.
`default_nettype none

interface rbm_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       drain;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output drain, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input drain, output ready);
endinterface

interface rbm_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_last, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rbm_fifo.sv -----
// Short job queue between front and back.
// No dependencies.
`default_nettype none

module rbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rbm_front.sv -----
// Front end: takes input words, tracks frame positions, decides write/emit, queues jobs.
// Uses rbm_pix_in_if.
`default_nettype none

module rbm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int SW  = $clog2(MAX_WINDOW),
  localparam int LGW = SW + WW,
  localparam int DW  = WW + 16,
  localparam int JW  = 43 + 2 * SW + 2 * CW
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           restart_i,
  input  logic [WW-1:0]  w_i,
  input  logic [15:0]    hgt_i,
  input  logic [LGW-1:0] lag_i,
  rbm_pix_in_if.sink     pix_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output logic [JW-1:0]  q_job_o
);

  typedef struct packed {
    logic          wr;
    logic [23:0]   pix;
    logic [SW-1:0] wslot;
    logic [CW-1:0] wcol;
    logic          emit;
    logic [15:0]   orow;
    logic [SW-1:0] oslot;
    logic [CW-1:0] ocol;
    logic          last;
  } job_t;

  logic [CW-1:0] icol_q, icol_d, ocol_q, ocol_d;
  logic [15:0]   irow_q, irow_d, orow_q, orow_d;
  logic [SW-1:0] islot_q, islot_d, oslot_q, oslot_d;
  logic [DW-1:0] d_q, d_d, d_inc;
  logic          full, acc, wr, emit, last;
  job_t          job;

  assign full        = (irow_q >= hgt_i);
  assign pix_i.ready = !q_full_i;
  assign acc         = pix_i.valid && !q_full_i;
  assign wr          = !full && !pix_i.drain;
  assign d_inc       = d_q + DW'(wr);
  // emit once the input runs a full lag ahead, or always once the frame is in
  assign emit        = full || (wr && (d_inc > DW'(lag_i)));
  assign last        = (orow_q == hgt_i - 16'd1) && (WW'(ocol_q) == w_i - WW'(1));

  always_comb begin
    job.wr    = wr;
    job.pix   = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
    job.wslot = islot_q;
    job.wcol  = icol_q;
    job.emit  = emit;
    job.orow  = orow_q;
    job.oslot = oslot_q;
    job.ocol  = ocol_q;
    job.last  = last;
  end

  assign q_job_o  = job;
  assign q_push_o = acc && (wr || emit);

  always_comb begin
    icol_d  = icol_q;
    irow_d  = irow_q;
    islot_d = islot_q;
    ocol_d  = ocol_q;
    orow_d  = orow_q;
    oslot_d = oslot_q;
    d_d     = d_q;
    if (restart_i) begin
      icol_d  = '0;
      irow_d  = '0;
      islot_d = '0;
      ocol_d  = '0;
      orow_d  = '0;
      oslot_d = '0;
      d_d     = '0;
    end else if (acc) begin
      if (wr) begin
        if (WW'(icol_q) + WW'(1) >= w_i) begin
          icol_d  = '0;
          irow_d  = irow_q + 16'd1;
          islot_d = (islot_q == SW'(MAX_WINDOW - 1)) ? '0 : islot_q + SW'(1);
        end else begin
          icol_d = icol_q + CW'(1);
        end
      end
      d_d = d_inc - DW'(emit);
      if (emit) begin
        if (last) begin
          // frame done: everything back to the origin
          icol_d  = '0;
          irow_d  = '0;
          islot_d = '0;
          ocol_d  = '0;
          orow_d  = '0;
          oslot_d = '0;
          d_d     = '0;
        end else if (WW'(ocol_q) + WW'(1) >= w_i) begin
          ocol_d  = '0;
          orow_d  = orow_q + 16'd1;
          oslot_d = (oslot_q == SW'(MAX_WINDOW - 1)) ? '0 : oslot_q + SW'(1);
        end else begin
          ocol_d = ocol_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icol_q  <= '0;
      irow_q  <= '0;
      islot_q <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
      oslot_q <= '0;
      d_q     <= '0;
    end else begin
      icol_q  <= icol_d;
      irow_q  <= irow_d;
      islot_q <= islot_d;
      ocol_q  <= ocol_d;
      orow_q  <= orow_d;
      oslot_q <= oslot_d;
      d_q     <= d_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rbm_back.sv -----
// Back end: writes pixels to the row store, sweeps the window, divides, presents result.
// Uses rbm_ram and rbm_pix_out_if.
`default_nettype none

module rbm_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15,
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int SW  = $clog2(MAX_WINDOW),
  localparam int JW  = 43 + 2 * SW + 2 * CW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [WW-1:0] w_i,
  input  logic [15:0]   hgt_i,
  input  logic [SW-1:0] h_i,
  input  logic          q_valid_i,
  input  logic [JW-1:0] q_job_i,
  output logic          q_pop_o,
  rbm_pix_out_if.source res_o
);

  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUMW  = 8 + NW;
  localparam int DCW   = $clog2(SUMW + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_TAIL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  typedef struct packed {
    logic          wr;
    logic [23:0]   pix;
    logic [SW-1:0] wslot;
    logic [CW-1:0] wcol;
    logic          emit;
    logic [15:0]   orow;
    logic [SW-1:0] oslot;
    logic [CW-1:0] ocol;
    logic          last;
  } job_t;

  job_t            job;
  logic [2:0]      state_q, state_d;
  logic [15:0]     y_q, r1_q;
  logic [CW-1:0]   x_q, c0_q, c1_q;
  logic [SW-1:0]   slot_q;
  logic            last_q, rdv_q;
  logic [NW-1:0]   n_q;
  logic [SUMW-1:0] sum_q [3];
  logic [SUMW-1:0] sum_nx [3];
  logic [NW-1:0]   rem_q [3];
  logic [NW-1:0]   rem_nx [3];
  logic [DCW-1:0]  dcnt_q;
  logic [23:0]     rdata;
  logic [7:0]      rd_ch [3];
  logic            take, re;
  logic [AW-1:0]   waddr, raddr;

  // window bounds of the job at the queue head
  logic [16:0]   rh;
  logic [15:0]   r0, r1;
  logic [SW-1:0] dr, slot0;
  logic [SW:0]   slot_wrap;
  logic [CW:0]   ch;
  logic [CW-1:0] c0, c1;

  assign job  = q_job_i;
  assign take = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o = take;

  always_comb begin
    rh        = 17'(job.orow) + 17'(h_i);
    r0        = (job.orow >= 16'(h_i)) ? job.orow - 16'(h_i) : 16'd0;
    r1        = (rh < 17'(hgt_i)) ? rh[15:0] : hgt_i - 16'd1;
    dr        = SW'(job.orow - r0);
    slot_wrap = (SW+1)'(job.oslot) + (SW+1)'(MAX_WINDOW) - (SW+1)'(dr);
    slot0     = (job.oslot >= dr) ? job.oslot - dr : slot_wrap[SW-1:0];
    ch        = (CW+1)'(job.ocol) + (CW+1)'(h_i);
    c0        = (job.ocol >= CW'(h_i)) ? job.ocol - CW'(h_i) : '0;
    c1        = (ch < (CW+1)'(w_i)) ? ch[CW-1:0] : CW'(w_i - WW'(1));
  end

  assign waddr = AW'(job.wslot) * AW'(MAX_WIDTH) + AW'(job.wcol);
  assign raddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(x_q);
  assign re    = (state_q == S_SUM);

  rbm_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (take && job.wr),
    .waddr_i (waddr),
    .wdata_i (job.pix),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_ch[0] = rdata[23:16];
  assign rd_ch[1] = rdata[15:8];
  assign rd_ch[2] = rdata[7:0];

  // one restoring divide step per channel
  always_comb begin
    logic [NW:0] sh;
    logic        ge;
    sh = '0;
    ge = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sh        = {rem_q[k], sum_q[k][SUMW-1]};
      ge        = (sh >= (NW+1)'(n_q));
      sh        = ge ? sh - (NW+1)'(n_q) : sh;
      rem_nx[k] = sh[NW-1:0];
      sum_nx[k] = {sum_q[k][SUMW-2:0], ge};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take && job.emit) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if ((x_q == c1_q) && (y_q == r1_q)) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == DCW'(SUMW - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      y_q    <= r0;
      r1_q   <= r1;
      x_q    <= c0;
      c0_q   <= c0;
      c1_q   <= c1;
      slot_q <= slot0;
      last_q <= job.last;
      n_q    <= '0;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
      end
    end
    if (state_q == S_SUM) begin
      if (x_q == c1_q) begin
        x_q    <= c0_q;
        y_q    <= y_q + 16'd1;
        slot_q <= (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + SW'(1);
      end else begin
        x_q <= x_q + CW'(1);
      end
    end
    if (rdv_q) begin
      n_q <= n_q + NW'(1);
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SUMW'(rd_ch[k]);
      end
    end
    if (state_q == S_TAIL) begin
      dcnt_q <= '0;
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= '0;
      end
    end
    if (state_q == S_DIV) begin
      dcnt_q <= dcnt_q + DCW'(1);
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= rem_nx[k];
        sum_q[k] <= sum_nx[k];
      end
    end
  end

  // after the divide, the sum registers hold the quotients
  assign res_o.valid      = (state_q == S_OUT);
  assign res_o.red_out    = sum_q[0][7:0];
  assign res_o.green_out  = sum_q[1][7:0];
  assign res_o.blue_out   = sum_q[2][7:0];
  assign res_o.frame_last = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_box_mean_filter.sv -----
// Top level of the RGB box mean filter: config registers, front, job queue, back.
// Depends on rbm_pkg, rbm_if, rbm_front, rbm_fifo, rbm_back.
//
// Usage:
//  - pix_i takes one word per pixel in raster order (red_in/green_in/blue_in); after the
//    frame's last pixel, words with drain=1 push out the pending results. drain words
//    before the frame is complete are taken and ignored.
//  - res_o gives one result word per emitting input word, in order; frame_last marks
//    the final pixel of the frame, after which a new frame starts.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write width, height, window; a write to a known
//    index restarts the frame. Write only while the block is idle.
// Back-end work:
//  - a word that only stores a pixel is written to the row store as it leaves the queue.
//  - a word that emits makes the back end read its N in-bounds window pixels through the
//    single read port of the row store (N at most 225 for a 15x15 window), then divide
//    the channel sums in the bit-serial divider and present the result.
//  - a two-entry job queue lets the front take the next word while the back works.
// Reset: positions clear, config returns to 640x480, window 3. The row store is not
// cleared. A stalled receiver holds the result; the queue then fills and pix_i.ready drops.
`default_nettype none

module rgb_box_mean_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rbm_pix_in_if.sink                    pix_i,
  rbm_pix_out_if.source                 res_o,
  input  logic                          cfg_we_i,
  input  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int SW  = $clog2(MAX_WINDOW);
  localparam int LGW = SW + WW;
  localparam int JW  = 43 + 2 * SW + 2 * CW;

  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [3:0]  win_q;
  logic        restart;

  // effective geometry
  logic [WW-1:0]  w_eff;
  logic [15:0]    hgt_eff;
  logic [5:0]     s_sat;
  logic [SW-1:0]  h_eff;
  logic [LGW-1:0] lag;

  // queue wiring
  logic          q_push, q_full, q_pop, q_valid;
  logic [JW-1:0] q_wjob, q_rjob;

  assign restart = cfg_we_i && ((cfg_idx_i == rbm_pkg::CFG_WIDTH) ||
                                (cfg_idx_i == rbm_pkg::CFG_HEIGHT) ||
                                (cfg_idx_i == rbm_pkg::CFG_WINDOW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rbm_pkg::RST_WIDTH;
      height_q <= rbm_pkg::RST_HEIGHT;
      win_q    <= rbm_pkg::RST_WINDOW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbm_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        rbm_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        rbm_pkg::CFG_WINDOW: win_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // width: zero acts as one, saturate at MAX_WIDTH
    if (width_q == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    hgt_eff = (height_q == 16'd0) ? 16'd1 : height_q;
    // window: clamp to 1..MAX_WINDOW, even sizes drop by one, keep half
    if (win_q == 4'd0) begin
      s_sat = 6'd1;
    end else if (32'(win_q) > 32'(MAX_WINDOW)) begin
      s_sat = 6'(MAX_WINDOW);
    end else begin
      s_sat = 6'(win_q);
    end
    if (!s_sat[0]) begin
      s_sat = s_sat - 6'd1;
    end
    h_eff = SW'(s_sat >> 1);
  end

  // result lags the input by half a window: h rows plus h pixels
  assign lag = LGW'(h_eff) * LGW'(w_eff) + LGW'(h_eff);

  rbm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .w_i       (w_eff),
    .hgt_i     (hgt_eff),
    .lag_i     (lag),
    .pix_i     (pix_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_job_o   (q_wjob)
  );

  rbm_fifo #(
    .WIDTH (JW),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rjob)
  );

  rbm_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .w_i       (w_eff),
    .hgt_i     (hgt_eff),
    .h_i       (h_eff),
    .q_valid_i (q_valid),
    .q_job_i   (q_rjob),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/rbm_checker.sv -----
// Port-level checker for rgb_box_mean_filter, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [24:0] out_word_i
);

  logic        in_acc, out_acc;
  logic [31:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words taken that may still yield a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 32'(in_acc) - 32'(out_acc);
    end
  end

  `RBM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `RBM_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_word_i), "result changed")
  `RBM_ASSERT(a_no_extra, out_valid_i |-> (pend_q != 32'd0), "result without input word")

endmodule

bind rgb_box_mean_filter rbm_checker u_rbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_word_i  ({res_o.red_out, res_o.green_out, res_o.blue_out, res_o.frame_last})
);

`default_nettype wire
